### rtl/assert_macros.svh
// Assertion macros shared by the bloom filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BFIP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BFIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bfip_pkg.sv
// Package with the types, codes and constants of the bloom filter engine.
package bfip_pkg;

    // Payload and register widths
    localparam int DATA_W    = 32;
    localparam int M_W       = 17;
    localparam int K_W       = 5;
    localparam int CFG_W     = 17;
    localparam int REG_IDX_W = 1;
    localparam int BIT_W     = 5;
    localparam int FACTOR_W  = 7;
    localparam int FIDX_W    = 4;

    // Register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_HASH_COUNT  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_BITS = 1'b1;

    // Operation codes of an input item
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Register reset values and fixed limits
    localparam logic [K_W-1:0] HASH_COUNT_RESET  = 5'd1;
    localparam int             FILTER_BITS_RESET = 65536;
    localparam int             FILTER_BITS_MIN   = 32;
    localparam int             FILTER_BITS_TOP   = (1 << M_W) - 1;
    localparam int             HASH_COUNT_TOP    = (1 << K_W) - 1;

    // Prime factor table
    localparam int                PRIME_COUNT = 15;
    localparam logic [FIDX_W-1:0] PRIME_LAST  = 4'(PRIME_COUNT - 1);

    // Remainder unit: bits retired per cycle and iterations per remainder
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = DATA_W / MOD_STEP;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    // Result of the remainder unit
    typedef struct packed {
        logic           done;
        logic [M_W-1:0] rem;
    } mod_res_t;

    // Access request to the filter store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

    function automatic logic [FACTOR_W-1:0] prime_factor(input logic [FIDX_W-1:0] idx);
        logic [FACTOR_W-1:0] f;
        case (idx)
            4'd0:    f = 7'd23;
            4'd1:    f = 7'd29;
            4'd2:    f = 7'd31;
            4'd3:    f = 7'd37;
            4'd4:    f = 7'd41;
            4'd5:    f = 7'd43;
            4'd6:    f = 7'd47;
            4'd7:    f = 7'd53;
            4'd8:    f = 7'd59;
            4'd9:    f = 7'd61;
            4'd10:   f = 7'd67;
            4'd11:   f = 7'd71;
            4'd12:   f = 7'd73;
            4'd13:   f = 7'd79;
            4'd14:   f = 7'd83;
            default: f = 7'd0;
        endcase
        return f;
    endfunction

endpackage

### rtl/bfip_req_if.sv
// Input channel: operation and key with valid/ready handshake.
interface bfip_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [bfip_pkg::DATA_W-1:0]  key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

### rtl/bfip_resp_if.sv
// Output channel: queried key and presence flag with valid/ready handshake.
interface bfip_resp_if;
    logic                         valid;
    logic                         ready;
    logic [bfip_pkg::DATA_W-1:0]  key_out;
    logic                         maybe_present;

    modport source (output valid, output key_out, output maybe_present, input ready);
    modport sink   (input valid, input key_out, input maybe_present, output ready);
endinterface

### rtl/bloom_filter_insert_probe_top.sv
// Bloom filter insert/query engine: hash sequencer around a remainder unit and a word store.
//
// Each accepted item runs k hash positions one after another (k = hash_count, 0 taken as 1,
// capped at MAX_HASHES). Each position runs through the remainder unit, which retires four
// dividend bits a cycle, then one store read and one check or write-back. The next item is
// taken only once the block is back in idle; a query leaves one result in an output
// register, and it stalls only while that register is still full. After reset the store is
// cleared one word a cycle, all ceil(MAX_FILTER_BITS/32) words (2048 at the default), and no
// item is accepted meanwhile; configuration writes are taken at any time but must only be made
// while the block is idle.
`include "assert_macros.svh"

module bloom_filter_insert_probe_top
#(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_HASHES      = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bfip_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [bfip_pkg::CFG_W-1:0]         cfg_data,
    bfip_req_if.sink                           req,
    bfip_resp_if.source                        resp
);

    localparam int STORE_WORDS = (MAX_FILTER_BITS + 31) / 32;
    localparam int WORD_AW     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    // Effective register limits
    localparam int M_CAP   = (MAX_FILTER_BITS > bfip_pkg::FILTER_BITS_TOP) ?
                             bfip_pkg::FILTER_BITS_TOP : MAX_FILTER_BITS;
    localparam int M_RST   = (M_CAP < bfip_pkg::FILTER_BITS_RESET) ?
                             M_CAP : bfip_pkg::FILTER_BITS_RESET;
    localparam int K_CAP   = (MAX_HASHES > bfip_pkg::HASH_COUNT_TOP) ?
                             bfip_pkg::HASH_COUNT_TOP : MAX_HASHES;
    localparam logic [bfip_pkg::M_W-1:0] M_MAX   = bfip_pkg::M_W'(M_CAP);
    localparam logic [bfip_pkg::M_W-1:0] M_MIN   = bfip_pkg::M_W'(bfip_pkg::FILTER_BITS_MIN);
    localparam logic [bfip_pkg::M_W-1:0] M_RESET = bfip_pkg::M_W'(M_RST);
    localparam logic [bfip_pkg::K_W-1:0] K_MAX   = bfip_pkg::K_W'(K_CAP);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MOD   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [bfip_pkg::K_W-1:0]         k_reg;
    logic [bfip_pkg::M_W-1:0]         m_reg;
    logic [bfip_pkg::K_W-1:0]         k_wr;
    logic [bfip_pkg::M_W-1:0]         m_wr;
    logic                             func_reg;
    logic [bfip_pkg::DATA_W-1:0]      key_reg;
    logic [bfip_pkg::K_W-1:0]         j_reg;
    logic [bfip_pkg::K_W-1:0]         j_next;
    logic [bfip_pkg::FIDX_W-1:0]      fidx_reg;
    logic [bfip_pkg::FIDX_W-1:0]      fidx_next;
    logic                             hit_reg;
    logic [WORD_AW-1:0]               addr_reg;
    logic [bfip_pkg::BIT_W-1:0]       bit_reg;
    logic                             out_valid_reg;
    logic [bfip_pkg::DATA_W-1:0]      out_key_reg;
    logic                             out_hit_reg;

    logic                             in_accept;
    logic                             last_hash;
    logic                             out_free;
    logic                             mod_start;
    logic [bfip_pkg::DATA_W-1:0]      hash_key;
    logic [bfip_pkg::K_W-1:0]         hash_j;
    logic [bfip_pkg::FIDX_W-1:0]      hash_fidx;
    logic [bfip_pkg::DATA_W+bfip_pkg::FACTOR_W-1:0] hash_prod;
    logic [bfip_pkg::DATA_W-1:0]      hash_val;
    logic [WORD_AW+bfip_pkg::M_W-1:0] pos_word;
    logic [WORD_AW-1:0]               st_addr;
    logic [bfip_pkg::DATA_W-1:0]      st_wdata;
    logic [bfip_pkg::DATA_W-1:0]      st_rdata;
    logic                             st_clear_busy;
    logic                             st_bit;
    bfip_pkg::store_ctl_t             st_ctl;
    bfip_pkg::mod_res_t               mod_res;

    // Clamp written register values to their effective range
    always_comb
    begin
        k_wr = cfg_data[bfip_pkg::K_W-1:0];
        if (k_wr == '0)
        begin
            k_wr = 5'd1;
        end
        else if (k_wr > K_MAX)
        begin
            k_wr = K_MAX;
        end
        m_wr = cfg_data[bfip_pkg::M_W-1:0];
        if (m_wr < M_MIN)
        begin
            m_wr = M_MIN;
        end
        else if (m_wr > M_MAX)
        begin
            m_wr = M_MAX;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= (bfip_pkg::HASH_COUNT_RESET > K_MAX) ? K_MAX : bfip_pkg::HASH_COUNT_RESET;
            m_reg <= M_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfip_pkg::REG_HASH_COUNT:  k_reg <= k_wr;
                bfip_pkg::REG_FILTER_BITS: m_reg <= m_wr;
            endcase
        end
    end

    // Handshake terms
    assign in_accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !st_clear_busy;
    assign last_hash = (j_reg == (k_reg - 1'b1));
    assign out_free  = !out_valid_reg || resp.ready;
    assign st_bit    = st_rdata[bit_reg];

    // Select the hash index and key for the next position
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            hash_key  = req.key;
            j_next    = '0;
            fidx_next = '0;
        end
        else
        begin
            hash_key  = key_reg;
            j_next    = j_reg + 1'b1;
            fidx_next = (fidx_reg == bfip_pkg::PRIME_LAST) ? '0 : fidx_reg + 1'b1;
        end
        hash_j    = j_next;
        hash_fidx = fidx_next;
        mod_start = in_accept || ((state_reg == S_CHECK) && !last_hash);
    end

    // Multiply by the prime factor and shift by the hash index, wrapping at 32 bits
    always_comb
    begin
        hash_prod = {{bfip_pkg::FACTOR_W{1'b0}}, hash_key} *
                    {{bfip_pkg::DATA_W{1'b0}}, bfip_pkg::prime_factor(hash_fidx)};
        hash_val  = hash_prod[bfip_pkg::DATA_W-1:0] << hash_j;
    end

    bfip_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_val),
        .divisor  (m_reg),
        .res      (mod_res)
    );

    // Word address of the finished position
    assign pos_word = {{WORD_AW{1'b0}}, mod_res.rem} >> bfip_pkg::BIT_W;

    // Store access: read when the position is ready, write back on insert
    always_comb
    begin
        st_ctl.rd_en = (state_reg == S_MOD) && mod_res.done;
        st_ctl.wr_en = (state_reg == S_CHECK) && (func_reg == bfip_pkg::FUNC_INSERT);
        st_addr      = (state_reg == S_MOD) ? pos_word[WORD_AW-1:0] : addr_reg;
        st_wdata     = st_rdata | (bfip_pkg::DATA_W'(1) << bit_reg);
    end

    bfip_store #(.WORDS(STORE_WORDS)) u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (st_ctl),
        .addr       (st_addr),
        .wdata      (st_wdata),
        .rdata      (st_rdata),
        .clear_busy (st_clear_busy)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_res.done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!last_hash)
                begin
                    state_next = S_MOD;
                end
                else if (func_reg == bfip_pkg::FUNC_QUERY)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item context, hash counters and hit accumulation
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= req.func;
            key_reg  <= req.key;
            hit_reg  <= 1'b1;
        end
        if (mod_start)
        begin
            j_reg    <= j_next;
            fidx_reg <= fidx_next;
        end
        if (st_ctl.rd_en)
        begin
            addr_reg <= pos_word[WORD_AW-1:0];
            bit_reg  <= mod_res.rem[bfip_pkg::BIT_W-1:0];
        end
        if (state_reg == S_CHECK)
        begin
            hit_reg <= hit_reg & st_bit;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_key_reg <= key_reg;
            out_hit_reg <= hit_reg;
        end
    end

    // Drive the output channel
    assign resp.valid         = out_valid_reg;
    assign resp.key_out       = out_key_reg;
    assign resp.maybe_present = out_hit_reg;

    `BFIP_ASSERT_SAME(a_write_on_insert, clk, rst_n, st_ctl.wr_en, (state_reg == S_CHECK) && (func_reg == bfip_pkg::FUNC_INSERT), "store written outside an insert")
    `BFIP_ASSERT_NEXT(a_result_from_out, clk, rst_n, (state_reg != S_OUT) && !out_valid_reg, !out_valid_reg, "result shown without a finished query")
    `BFIP_ASSERT_SAME(a_hash_in_range, clk, rst_n, state_reg == S_CHECK, j_reg < k_reg, "hash index beyond hash count")

endmodule

### rtl/bfip_mod.sv
// Iterative remainder unit: 32-bit dividend modulo a 17-bit divisor, MOD_STEP bits a cycle.
`include "assert_macros.svh"

module bfip_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bfip_pkg::DATA_W-1:0]   dividend,
    input  logic [bfip_pkg::M_W-1:0]      divisor,
    output bfip_pkg::mod_res_t            res
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [bfip_pkg::MOD_CNT_W-1:0]   cnt_reg;
    logic [bfip_pkg::DATA_W-1:0]      dvd_reg;
    logic [bfip_pkg::DATA_W-1:0]      dvd_next;
    logic [bfip_pkg::M_W-1:0]         rem_reg;
    logic [bfip_pkg::M_W-1:0]         rem_next;
    logic [bfip_pkg::M_W:0]           r;
    logic [bfip_pkg::DATA_W-1:0]      d;

    localparam logic [bfip_pkg::MOD_CNT_W-1:0] CNT_LAST =
        bfip_pkg::MOD_CNT_W'(bfip_pkg::MOD_CYCLES - 1);

    // Shift in dividend bits, subtract the divisor whenever it fits
    always_comb
    begin
        r = {1'b0, rem_reg};
        d = dvd_reg;
        for (int i = 0; i < bfip_pkg::MOD_STEP; i++)
        begin
            r = {r[bfip_pkg::M_W-1:0], d[bfip_pkg::DATA_W-1]};
            d = {d[bfip_pkg::DATA_W-2:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
        end
        rem_next = r[bfip_pkg::M_W-1:0];
        dvd_next = d;
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the partial remainder and the remaining dividend bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

    `BFIP_ASSERT_SAME(a_no_restart, clk, rst_n, start, !busy_reg, "remainder unit restarted while busy")
    `BFIP_ASSERT_SAME(a_rem_range, clk, rst_n, done_reg, rem_reg < divisor, "remainder not below divisor")

endmodule

### rtl/bfip_store.sv
// Filter store: synchronous word memory with a clearing pass after reset.
`include "assert_macros.svh"

module bfip_store
#(
    parameter int WORDS = 2048
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bfip_pkg::store_ctl_t                   ctl,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] addr,
    input  logic [bfip_pkg::DATA_W-1:0]            wdata,
    output logic [bfip_pkg::DATA_W-1:0]            rdata,
    output logic                                   clear_busy
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(WORDS - 1);

    logic [bfip_pkg::DATA_W-1:0] mem_reg [WORDS];
    logic [bfip_pkg::DATA_W-1:0] rdata_reg;
    logic                        clr_busy_reg;
    logic [AW-1:0]               clr_ptr_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [bfip_pkg::DATA_W-1:0] mem_wdata;

    // Walk every word once after reset, writing zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == ADDR_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Give the clearing pass the write port
    always_comb
    begin
        mem_we    = clr_busy_reg | ctl.wr_en;
        mem_waddr = clr_busy_reg ? clr_ptr_reg : addr;
        mem_wdata = clr_busy_reg ? '0 : wdata;
    end

    // Memory array: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

    `BFIP_ASSERT_SAME(a_idle_clear, clk, rst_n, clr_busy_reg, !(ctl.rd_en || ctl.wr_en), "store accessed during clearing pass")

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the bloom filter engine: insert/query traffic checked against a bit-level predictor.
module tb_top;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int STORE_WORDS     = 2048;
    localparam int TB_MAX_BITS     = 65536;
    localparam int TB_MAX_HASHES   = 16;
    localparam int DRAIN_CYCLES    = 200;
    localparam int STALL_LIMIT     = 12000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;

    typedef struct packed {
        logic                        func;
        logic [bfip_pkg::DATA_W-1:0] key;
    } filter_op_t;

    typedef struct packed {
        logic [bfip_pkg::DATA_W-1:0] key;
        logic                        hit;
    } probe_res_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bfip_pkg::REG_IDX_W-1:0] cfg_index;
    logic [bfip_pkg::CFG_W-1:0]     cfg_data;

    bfip_req_if  req ();
    bfip_resp_if resp ();

    bloom_filter_insert_probe_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .resp      (resp)
    );

    // Predictor state: own copy of the filter words and the two registers
    int unsigned hash_prime [15] = '{23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73, 79, 83};
    logic [31:0]                 filter_words [STORE_WORDS];
    logic [bfip_pkg::K_W-1:0]    hash_count_q;
    logic [bfip_pkg::M_W-1:0]    filter_bits_q;

    filter_op_t                  pending_ops [$];
    probe_res_t                  expected_results [$];
    logic [bfip_pkg::DATA_W-1:0] inserted_keys [$];

    filter_op_t        next_op;
    probe_res_t        oldest_result;
    int unsigned       burst_left;
    int unsigned       gap_left;
    logic [15:0]       ready_pattern;
    logic [7:0]        pattern_age;
    int unsigned       idle_cycles;
    int unsigned       mismatches;
    int unsigned       insert_count;
    int unsigned       query_count;
    int unsigned       hit_count;
    int unsigned       setting_count;

    always #HALF_PERIOD clk = ~clk;

    // Apply one operation to the predicted store; return the all-bits-set flag
    function automatic logic run_filter_op(input filter_op_t op);
        int unsigned k;
        int unsigned m;
        int unsigned pos;
        int unsigned word;
        logic [31:0] prod;
        logic        all_set;
        k = hash_count_q;
        if (k < 1) k = 1;
        if (k > TB_MAX_HASHES) k = TB_MAX_HASHES;
        m = filter_bits_q;
        if (m < 32) m = 32;
        if (m > TB_MAX_BITS) m = TB_MAX_BITS;
        all_set = 1'b1;
        for (int unsigned j = 0; j < k; j++) begin
            prod = op.key * hash_prime[j % 15];
            prod = (j >= 32) ? 32'd0 : (prod << j);
            pos  = prod % m;
            word = (pos >> 5) % STORE_WORDS;
            if (op.func == bfip_pkg::FUNC_INSERT)
                filter_words[word][pos % 32] = 1'b1;
            else if (!filter_words[word][pos % 32])
                all_set = 1'b0;
        end
        return all_set;
    endfunction

    // Random key, with the bit extremes mixed in
    function automatic logic [bfip_pkg::DATA_W-1:0] random_key();
        logic [bfip_pkg::DATA_W-1:0] one_hot;
        one_hot = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic func, input logic [bfip_pkg::DATA_W-1:0] key);
        pending_ops.push_back('{func: func, key: key});
    endtask

    // Random item: inserts, queries of stored keys and queries of fresh keys
    task automatic queue_random_op();
        int unsigned                 pick;
        logic [bfip_pkg::DATA_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            key = random_key();
            inserted_keys.push_back(key);
            queue_op(bfip_pkg::FUNC_INSERT, key);
        end
        else if (pick < 75 && inserted_keys.size() != 0)
            queue_op(bfip_pkg::FUNC_QUERY,
                     inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
        else
            queue_op(bfip_pkg::FUNC_QUERY, random_key());
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [bfip_pkg::REG_IDX_W-1:0] idx,
                             input logic [bfip_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bfip_pkg::REG_HASH_COUNT)
            hash_count_q = value[bfip_pkg::K_W-1:0];
        else
            filter_bits_q = value[bfip_pkg::M_W-1:0];
    endtask

    task automatic write_setting(input logic [bfip_pkg::CFG_W-1:0] hashes,
                                 input logic [bfip_pkg::CFG_W-1:0] bits);
        write_reg(bfip_pkg::REG_HASH_COUNT, hashes);
        write_reg(bfip_pkg::REG_FILTER_BITS, bits);
        setting_count++;
    endtask

    // Hold until every item is taken and every result is back, then let inserts finish
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_ops.size() != 0 || req.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req.valid  <= 1'b0;
            req.func   <= bfip_pkg::FUNC_INSERT;
            req.key    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!req.valid || req.ready) begin
            if (gap_left != 0) begin
                req.valid <= 1'b0;
                gap_left  <= gap_left - 1;
            end
            else if (pending_ops.size() != 0) begin
                next_op = pending_ops.pop_front();
                req.valid <= 1'b1;
                req.func  <= next_op.func;
                req.key   <= next_op.key;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                              : $urandom_range(0, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Receiver: rotate a ready pattern, reload it whenever the 8-bit age counter wraps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            resp.ready    <= 1'b0;
            ready_pattern <= 16'hFFFF;
            pattern_age   <= '0;
        end
        else begin
            pattern_age <= pattern_age + 1'b1;
            if (pattern_age == 8'hFF) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern <= 16'hFFFF;
                    1:       ready_pattern <= 16'($urandom) | 16'h0001;
                    default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
            else
                ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            resp.ready <= ready_pattern[15];
        end
    end

    // Monitor: predict on each accepted item, check each accepted result
    always @(posedge clk) begin
        if (rst_n) begin
            if (req.valid && req.ready) begin
                if (req.func == bfip_pkg::FUNC_INSERT) begin
                    void'(run_filter_op('{func: req.func, key: req.key}));
                    insert_count++;
                end
                else begin
                    expected_results.push_back('{key: req.key,
                        hit: run_filter_op('{func: req.func, key: req.key})});
                    query_count++;
                end
            end
            if (resp.valid && resp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: key_out %h", resp.key_out);
                    mismatches++;
                end
                else begin
                    oldest_result = expected_results.pop_front();
                    if (resp.key_out !== oldest_result.key) begin
                        $error("key_out: expected %h, actual %h", oldest_result.key,
                               resp.key_out);
                        mismatches++;
                    end
                    if (resp.maybe_present !== oldest_result.hit) begin
                        $error("maybe_present: expected %b, actual %b", oldest_result.hit,
                               resp.maybe_present);
                        mismatches++;
                    end
                    if (resp.maybe_present === 1'b1)
                        hit_count++;
                end
            end
        end
    end

    // Watchdog: stop when no handshake happens for too long
    always @(posedge clk) begin
        if (!rst_n || (req.valid && req.ready) || (resp.valid && resp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [bfip_pkg::CFG_W-1:0] hashes;
        logic [bfip_pkg::CFG_W-1:0] bits;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= bfip_pkg::REG_HASH_COUNT;
        cfg_data  <= '0;
        hash_count_q  = bfip_pkg::HASH_COUNT_RESET;
        filter_bits_q = bfip_pkg::M_W'(bfip_pkg::FILTER_BITS_RESET);
        mismatches    = 0;
        insert_count  = 0;
        query_count   = 0;
        hit_count     = 0;
        setting_count = 1;
        foreach (filter_words[i])
            filter_words[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty store, then keys at the extremes
        queue_op(bfip_pkg::FUNC_QUERY, 32'h0000_0000);
        queue_op(bfip_pkg::FUNC_INSERT, 32'h0000_0000);
        queue_op(bfip_pkg::FUNC_QUERY, 32'h0000_0000);
        queue_op(bfip_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
        queue_op(bfip_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
        queue_op(bfip_pkg::FUNC_QUERY, 32'h8000_0000);
        wait_drained();

        // Zero hash count and a size below the minimum
        write_setting(17'd0, 17'd0);
        queue_op(bfip_pkg::FUNC_INSERT, 32'hDEAD_BEEF);
        queue_op(bfip_pkg::FUNC_QUERY, 32'hDEAD_BEEF);
        queue_op(bfip_pkg::FUNC_QUERY, 32'h0000_0001);
        wait_drained();

        // Hash count and size above their limits, upper data bits set
        write_setting(17'h1FFFF, 17'h1FFFF);
        queue_op(bfip_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
        queue_op(bfip_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
        queue_op(bfip_pkg::FUNC_QUERY, 32'hA5A5_A5A5);
        wait_drained();

        // Most hashes over a partial last word
        write_setting(17'd16, 17'd100);
        queue_op(bfip_pkg::FUNC_INSERT, 32'h0000_0007);
        queue_op(bfip_pkg::FUNC_QUERY, 32'h0000_0007);
        queue_op(bfip_pkg::FUNC_QUERY, 32'h5555_5555);
        queue_op(bfip_pkg::FUNC_INSERT, 32'h8000_0000);
        queue_op(bfip_pkg::FUNC_QUERY, 32'h8000_0000);
        wait_drained();

        // Random phases, each under a fresh setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:       hashes = 17'd0;
                1:       hashes = 17'($urandom_range(17, 31));
                2:       hashes = 17'd16;
                default: hashes = 17'($urandom_range(1, 16));
            endcase
            hashes[bfip_pkg::CFG_W-1:bfip_pkg::K_W] = ($urandom_range(0, 1) == 0) ?
                                                      '0 : 12'($urandom);
            case ($urandom_range(0, 9))
                0:       bits = 17'($urandom_range(0, 31));
                1:       bits = 17'($urandom_range(65537, 131071));
                2:       bits = 17'd65536;
                3:       bits = 17'd32;
                4, 5:    bits = 17'($urandom_range(33, 2048));
                default: bits = 17'($urandom_range(33, 65535));
            endcase
            write_setting(hashes, bits);
            repeat (ITEMS_PER_PHASE) queue_random_op();
            wait_drained();
        end

        $display("Ran %0d inserts and %0d queries (%0d reported present) over %0d settings.",
                 insert_count, query_count, hit_count, setting_count);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
